// ===== hdl/dtnm_pkg.sv =====
// Shared types and constants of the double-threshold neighbor mask block.
package dtnm_pkg;

	localparam int unsigned PIX_W         = 8;
	localparam int unsigned SIZE_W        = 11;
	localparam int unsigned POS_W         = 10;
	localparam int unsigned CFG_IDX_W     = 2;
	localparam int unsigned CFG_DATA_W    = 11;
	localparam int unsigned MAX_WIDTH_DEF = 1024;
	localparam int unsigned MAX_HEIGHT    = 1024;
	localparam int unsigned OQ_DEPTH      = 4;
	localparam int unsigned LINE_WORD_W   = 4;

	localparam logic [PIX_W-1:0]  LOW_THR_RST  = 8'd215;
	localparam logic [PIX_W-1:0]  HIGH_THR_RST = 8'd230;
	localparam logic [SIZE_W-1:0] FRAME_W_RST  = 11'd640;
	localparam logic [SIZE_W-1:0] FRAME_H_RST  = 11'd480;

	typedef enum logic [1:0] {
		CLS_BG     = 2'd0,
		CLS_MID    = 2'd1,
		CLS_STRONG = 2'd2
	} cls_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOW_THR  = 2'd0,
		REG_HIGH_THR = 2'd1,
		REG_FRAME_W  = 2'd2,
		REG_FRAME_H  = 2'd3
	} cfg_reg_t;

	// one column of the window: classes of three rows plus position tags
	typedef struct packed {
		logic             v;
		cls_t             up;
		cls_t             mid;
		cls_t             down;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic             first_col;
		logic             last_col;
		logic             last_row;
		logic             has_above;
		logic             inner_row;
	} col_t;

	// results caused by one pixel: A is the pixel above, B the pixel itself
	typedef struct packed {
		logic             has_a;
		logic             has_b;
		logic             bit_a;
		logic             bit_b;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic             last_col;
	} oq_rec_t;

	typedef struct packed {
		logic             mask_bit;
		logic [POS_W-1:0] pixel_row;
		logic [POS_W-1:0] pixel_col;
		logic             frame_done;
		logic             run_last;
	} res_t;

endpackage

// ===== hdl/dtnm_ram.sv =====
// Generic RAM: one write port, two registered read ports, read-first.
module dtnm_ram #(
	parameter int unsigned WIDTH = 4,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

// ===== hdl/dtnm_cell.sv =====
// Window cell: holds one column of classes and hands it on to its neighbor.
module dtnm_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  dtnm_pkg::col_t d,
	output dtnm_pkg::col_t q
);
	import dtnm_pkg::*;

	logic v_q;
	col_t pay_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (load) begin
			v_q <= d.v;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pay_q <= d;
		end
	end

	always_comb begin
		q = pay_q;
		q.v = v_q;
	end

endmodule

// ===== hdl/dtnm_outq.sv =====
// Result queue: one record per pixel, unrolled into one or two result items.
module dtnm_outq #(
	parameter int unsigned DEPTH = dtnm_pkg::OQ_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  dtnm_pkg::oq_rec_t          push_rec,
	output logic [$clog2(DEPTH+1)-1:0] count,
	output logic                       out_valid,
	input  logic                       out_ready,
	output dtnm_pkg::res_t             res
);
	import dtnm_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH+1);

	oq_rec_t          mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             phase_q;
	oq_rec_t          head;
	logic             emit_b;
	logic             fire;
	logic             pop;

	assign head      = mem_q[rd_ptr_q];
	assign out_valid = (count_q != '0);
	assign count     = count_q;
	assign emit_b    = !head.has_a || phase_q;
	assign fire      = out_valid && out_ready;
	assign pop       = fire && (emit_b || !head.has_b);

	always_comb begin
		res.pixel_col = head.col;
		if (emit_b) begin
			res.mask_bit   = head.bit_b;
			res.pixel_row  = head.row;
			res.frame_done = head.last_col;
			res.run_last   = 1'b1;
		end else begin
			res.mask_bit   = head.bit_a;
			res.pixel_row  = head.row - POS_W'(1);
			res.frame_done = 1'b0;
			res.run_last   = !head.has_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			phase_q  <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_q + PTR_W'(1);
				phase_q  <= 1'b0;
			end else if (fire) begin
				phase_q <= 1'b1;
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

endmodule

// ===== hdl/double_threshold_neighbor_mask.sv =====
// Top level of the double-threshold mask with a four-neighbor strong test.
//
// Gray pixels come in raster order, one item per pixel, and each pixel is
// classed strong (below low_threshold), middle (below high_threshold) or
// background. Strong gives mask 1, background 0; a middle pixel gives 1 only
// off the frame border and with a strong up, down, left or right neighbor.
// A pixel's result leaves when the pixel below it is taken in, so rows other
// than the last give one result per pixel (none on row 0), and the last row
// gives two: the pixel above, then the pixel itself. Rate: one pixel per
// clock on every row but the last, while the result queue has room; on the
// last row two results per pixel share the single output port. The
// pipeline is the pixel counters and class compare, the line store read
// (two read ports: the current column and the one to its right), then a
// chain of column cells that keeps the left column, then a four-entry
// result queue. Input ready follows a credit check on that queue. The line
// store keeps one word per column holding the classes of the two rows
// above; it needs no clearing pass, since entries of a row not yet written
// are never used. Frame sizes are clamped to 1..MAX_WIDTH and 1..1024.
// Configuration is written through cfg_we / cfg_index / cfg_data; the user
// must do so only while the block is idle; the block does not enforce it.
module double_threshold_neighbor_mask #(
	parameter int unsigned MAX_WIDTH = dtnm_pkg::MAX_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [dtnm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dtnm_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [dtnm_pkg::PIX_W-1:0]          gray_pixel,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                mask_bit,
	output logic [dtnm_pkg::POS_W-1:0]          pixel_row,
	output logic [dtnm_pkg::POS_W-1:0]          pixel_col,
	output logic                                frame_done,
	output logic                                run_last
);
	import dtnm_pkg::*;

	localparam int unsigned COL_W    = $clog2(MAX_WIDTH);
	localparam int unsigned WCMP     = (COL_W + 1 > SIZE_W) ? COL_W + 1 : SIZE_W;
	localparam int unsigned OQ_CNT_W = $clog2(OQ_DEPTH+1);

	// configuration
	logic [PIX_W-1:0]  low_thr_q;
	logic [PIX_W-1:0]  high_thr_q;
	logic [SIZE_W-1:0] frame_w_q;
	logic [SIZE_W-1:0] frame_h_q;

	// position of the next pixel
	logic [COL_W-1:0]  col_q;
	logic [POS_W-1:0]  row_q;

	logic              accept;
	logic [WCMP-1:0]   w_ext;
	logic [WCMP-1:0]   w_eff;
	logic [SIZE_W-1:0] h_eff;
	logic              last_col;
	logic              last_row;
	cls_t              cls_in;
	col_t              col_new;
	logic [COL_W-1:0]  raddr_b;

	// stage 1
	logic [COL_W-1:0]       col_addr_s1;
	logic                   fwd_a_s1;
	logic                   fwd_b_s1;
	logic [LINE_WORD_W-1:0] fwd_word_s1;
	col_t                   col_s1;
	col_t                   col_left;
	col_t                   col_cur;
	logic                   left_strong;

	logic [LINE_WORD_W-1:0] rdata_a;
	logic [LINE_WORD_W-1:0] rdata_b;
	logic [LINE_WORD_W-1:0] word_a;
	logic [LINE_WORD_W-1:0] word_b;
	logic [LINE_WORD_W-1:0] wdata;
	cls_t                   right_cls;
	logic                   nb_strong;
	logic                   inner;

	oq_rec_t             rec;
	logic                push;
	logic [OQ_CNT_W-1:0] oq_count;
	logic [OQ_CNT_W:0]   pending;
	res_t                res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_thr_q  <= LOW_THR_RST;
			high_thr_q <= HIGH_THR_RST;
			frame_w_q  <= FRAME_W_RST;
			frame_h_q  <= FRAME_H_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_LOW_THR:  low_thr_q  <= cfg_data[PIX_W-1:0];
				REG_HIGH_THR: high_thr_q <= cfg_data[PIX_W-1:0];
				REG_FRAME_W:  frame_w_q  <= cfg_data[SIZE_W-1:0];
				REG_FRAME_H:  frame_h_q  <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// one queue slot per pixel still in flight, plus the one being taken
	assign pending  = (OQ_CNT_W+1)'(oq_count) + (OQ_CNT_W+1)'(col_s1.v);
	assign in_ready = (pending < (OQ_CNT_W+1)'(OQ_DEPTH));
	assign accept   = in_valid && in_ready;

	// clamped frame size, current values
	assign w_ext = WCMP'(frame_w_q);
	always_comb begin
		if (frame_w_q == '0) begin
			w_eff = WCMP'(1);
		end else if (w_ext > WCMP'(MAX_WIDTH)) begin
			w_eff = WCMP'(MAX_WIDTH);
		end else begin
			w_eff = w_ext;
		end
		if (frame_h_q == '0) begin
			h_eff = SIZE_W'(1);
		end else if (frame_h_q > SIZE_W'(MAX_HEIGHT)) begin
			h_eff = SIZE_W'(MAX_HEIGHT);
		end else begin
			h_eff = frame_h_q;
		end
	end

	assign last_col = (WCMP'(col_q) + WCMP'(1)) >= w_eff;
	assign last_row = (SIZE_W'(row_q) + SIZE_W'(1)) >= h_eff;

	// strong is tested first, so a low threshold above the high one still wins
	always_comb begin
		if (gray_pixel < low_thr_q) begin
			cls_in = CLS_STRONG;
		end else if (gray_pixel < high_thr_q) begin
			cls_in = CLS_MID;
		end else begin
			cls_in = CLS_BG;
		end
	end

	always_comb begin
		col_new.v         = accept;
		col_new.up        = CLS_BG;
		col_new.mid       = CLS_BG;
		col_new.down      = cls_in;
		col_new.row       = row_q;
		col_new.col       = POS_W'(col_q);
		col_new.first_col = (col_q == '0);
		col_new.last_col  = last_col;
		col_new.last_row  = last_row;
		col_new.has_above = (row_q != '0);
		col_new.inner_row = (row_q >= POS_W'(2)) && (SIZE_W'(row_q) < h_eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + POS_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// right-hand column; at the top column it is never used
	assign raddr_b = (col_q == COL_W'(MAX_WIDTH-1)) ? col_q : col_q + COL_W'(1);

	// word per column: [3:2] class of the newer row, [1:0] of the older row
	dtnm_ram #(
		.WIDTH(LINE_WORD_W),
		.DEPTH(MAX_WIDTH)
	) u_line (
		.clk    (clk),
		.we     (col_s1.v),
		.waddr  (col_addr_s1),
		.wdata  (wdata),
		.re     (accept),
		.raddr_a(col_q),
		.raddr_b(raddr_b),
		.rdata_a(rdata_a),
		.rdata_b(rdata_b)
	);

	// same-cycle write and read of one column: take the written word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_a_s1 <= 1'b0;
			fwd_b_s1 <= 1'b0;
		end else begin
			fwd_a_s1 <= accept && col_s1.v && (col_addr_s1 == col_q);
			fwd_b_s1 <= accept && col_s1.v && (col_addr_s1 == raddr_b);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_addr_s1 <= col_q;
		end
		fwd_word_s1 <= wdata;
	end

	// cell chain: stage 1 column, then the column to its left
	dtnm_cell u_cell_s1 (
		.clk   (clk),
		.arst_n(arst_n),
		.load  (1'b1),
		.d     (col_new),
		.q     (col_s1)
	);

	assign word_a = fwd_a_s1 ? fwd_word_s1 : rdata_a;
	assign word_b = fwd_b_s1 ? fwd_word_s1 : rdata_b;

	always_comb begin
		col_cur     = col_s1;
		col_cur.mid = cls_t'(word_a[3:2]);
		col_cur.up  = cls_t'(word_a[1:0]);
	end

	dtnm_cell u_cell_left (
		.clk   (clk),
		.arst_n(arst_n),
		.load  (col_s1.v),
		.d     (col_cur),
		.q     (col_left)
	);

	assign left_strong = (col_left.mid == CLS_STRONG);

	// current row moves to the newer half, the row above to the older half
	assign wdata     = {col_s1.down, col_cur.mid};
	assign right_cls = cls_t'(word_b[3:2]);

	assign inner     = col_s1.inner_row && !col_s1.first_col && !col_s1.last_col;
	assign nb_strong = (col_cur.up == CLS_STRONG) || (col_s1.down == CLS_STRONG) ||
	                   left_strong || (right_cls == CLS_STRONG);

	always_comb begin
		rec.has_a    = col_s1.has_above;
		rec.has_b    = col_s1.last_row;
		rec.bit_a    = (col_cur.mid == CLS_STRONG) ||
		               ((col_cur.mid == CLS_MID) && inner && nb_strong);
		rec.bit_b    = (col_s1.down == CLS_STRONG);
		rec.row      = col_s1.row;
		rec.col      = col_s1.col;
		rec.last_col = col_s1.last_col;
	end

	assign push = col_s1.v && (col_s1.has_above || col_s1.last_row);

	dtnm_outq #(
		.DEPTH(OQ_DEPTH)
	) u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (rec),
		.count    (oq_count),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.res      (res)
	);

	assign mask_bit   = res.mask_bit;
	assign pixel_row  = res.pixel_row;
	assign pixel_col  = res.pixel_col;
	assign frame_done = res.frame_done;
	assign run_last   = res.run_last;

	// credit check keeps the result queue from overflowing
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (oq_count < OQ_CNT_W'(OQ_DEPTH)))
		else $error("result queue overflow");

	// forwarding only ever pairs with a pixel in stage 1
	a_fwd_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(fwd_a_s1 || fwd_b_s1) |-> col_s1.v)
		else $error("forwarded word without a pixel in stage 1");

	// the frame's final result closes its pixel's run
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_done) |-> run_last)
		else $error("frame_done on a result that is not the last of its run");

	// the first of a result pair is followed at once by the second
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !run_last) |=> out_valid)
		else $error("second result of a pair missing");

endmodule

// ===== bench/mask_checker.sv =====
// Checker for the double-threshold neighbor mask: snoops the ports, predicts and compares.
`timescale 1ns / 100ps

module mask_checker #(
	parameter int unsigned MAX_WIDTH = dtnm_pkg::MAX_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [dtnm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dtnm_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic [dtnm_pkg::PIX_W-1:0]      gray_pixel,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  logic                            mask_bit,
	input  logic [dtnm_pkg::POS_W-1:0]      pixel_row,
	input  logic [dtnm_pkg::POS_W-1:0]      pixel_col,
	input  logic                            frame_done,
	input  logic                            run_last,
	output int unsigned                     masks_owed,
	output int unsigned                     mismatches
);
	import dtnm_pkg::*;

	cls_t              line_cls [2*MAX_WIDTH];
	logic [PIX_W-1:0]  low_thr;
	logic [PIX_W-1:0]  high_thr;
	logic [SIZE_W-1:0] frame_w;
	logic [SIZE_W-1:0] frame_h;
	int unsigned       row_pos;
	int unsigned       col_pos;
	res_t              pending_masks [$];

	function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	// one pixel in: class it, emit the pixel above and, on the last row, itself
	task automatic predict_mask(input logic [PIX_W-1:0] pix);
		int unsigned w, h, r, c, cur, prev;
		cls_t        cls, above;
		logic        hit, last_row, last_col;
		res_t        rec;
		w = clamp_size(frame_w, MAX_WIDTH);
		h = clamp_size(frame_h, MAX_HEIGHT);
		r = row_pos;
		c = col_pos;
		if (pix < low_thr) cls = CLS_STRONG;
		else if (pix < high_thr) cls = CLS_MID;
		else cls = CLS_BG;
		cur      = (r % 2) * MAX_WIDTH + c;
		prev     = ((r + 1) % 2) * MAX_WIDTH;
		last_row = (r + 1 >= h);
		last_col = (c + 1 >= w);
		if (r >= 1) begin
			above = line_cls[prev + c];
			hit   = 1'b0;
			if (above == CLS_STRONG) begin
				hit = 1'b1;
			end else if (above == CLS_MID && r - 1 > 0 && r < h && c > 0 && c + 1 < w) begin
				hit = (line_cls[cur] == CLS_STRONG) || (cls == CLS_STRONG) ||
				      (line_cls[prev + c - 1] == CLS_STRONG) ||
				      (line_cls[prev + c + 1] == CLS_STRONG);
			end
			rec.mask_bit   = hit;
			rec.pixel_row  = POS_W'(r - 1);
			rec.pixel_col  = POS_W'(c);
			rec.frame_done = 1'b0;
			rec.run_last   = ~last_row;
			pending_masks.push_back(rec);
		end
		line_cls[cur] = cls;
		if (last_row) begin
			rec.mask_bit   = (cls == CLS_STRONG);
			rec.pixel_row  = POS_W'(r);
			rec.pixel_col  = POS_W'(c);
			rec.frame_done = last_col;
			rec.run_last   = 1'b1;
			pending_masks.push_back(rec);
		end
		if (last_col) begin
			col_pos = 0;
			row_pos = last_row ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
		end
	endtask

	task automatic check_field(input string name, input logic [POS_W-1:0] want,
	                           input logic [POS_W-1:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			for (int i = 0; i < 2*MAX_WIDTH; i++) line_cls[i] = CLS_BG;
			low_thr  = LOW_THR_RST;
			high_thr = HIGH_THR_RST;
			frame_w  = FRAME_W_RST;
			frame_h  = FRAME_H_RST;
			row_pos  = 0;
			col_pos  = 0;
			pending_masks.delete();
			masks_owed = 0;
			mismatches = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_LOW_THR:  low_thr  = cfg_data[PIX_W-1:0];
					REG_HIGH_THR: high_thr = cfg_data[PIX_W-1:0];
					REG_FRAME_W:  frame_w  = cfg_data;
					REG_FRAME_H:  frame_h  = cfg_data;
					default: ;
				endcase
			end
			// results first, so a result can never match an item taken at the same edge
			if (out_valid && out_ready) begin
				if (pending_masks.size() == 0) begin
					$display("%0t ns: unexpected result, expected none, got row %0d col %0d",
					         $time, pixel_row, pixel_col);
					mismatches++;
				end else begin
					want = pending_masks.pop_front();
					check_field("mask_bit", want.mask_bit, mask_bit);
					check_field("pixel_row", want.pixel_row, pixel_row);
					check_field("pixel_col", want.pixel_col, pixel_col);
					check_field("frame_done", want.frame_done, frame_done);
					check_field("run_last", want.run_last, run_last);
				end
			end
			if (in_valid && in_ready) predict_mask(gray_pixel);
			masks_owed = pending_masks.size();
		end
	end

endmodule

// ===== bench/tb_top.sv =====
// Top of the mask testbench: clock, reset, pixel and config stimulus, verdict.
`timescale 1ns / 100ps

module tb_top;
	import dtnm_pkg::*;

	// 4x4 neighbor test frame, raster order, low 100 / high 200:
	//   bg  S   bg  M      (1,1) middle, only up is strong
	//   bg  M   M   S      (1,2) middle, only right is strong
	//   S   M   M   bg     (2,1) middle, only left is strong
	//   M   bg  S   bg     (2,2) middle, only down is strong
	// border middles sit next to strong pixels and must still give 0
	localparam logic [16*PIX_W-1:0] NEIGHBOR_GRID = {
		8'd255, 8'd0,   8'd200, 8'd150,
		8'd200, 8'd150, 8'd199, 8'd99,
		8'd0,   8'd100, 8'd150, 8'd255,
		8'd150, 8'd200, 8'd99,  8'd255
	};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	cfg_reg_t              cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [PIX_W-1:0]      gray_pixel;
	logic                  out_valid;
	logic                  out_ready;
	logic                  mask_bit;
	logic [POS_W-1:0]      pixel_row;
	logic [POS_W-1:0]      pixel_col;
	logic                  frame_done;
	logic                  run_last;

	int unsigned masks_owed;
	int unsigned mismatches;

	int unsigned small_items;   // pixels sent in small random frames
	int unsigned burst_left;    // items left in the current sender burst
	int unsigned low_now;       // thresholds as last written, to steer levels
	int unsigned high_now;
	bit          hold_request;  // asks the receiver for one long hold-off
	bit          hold_done;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	double_threshold_neighbor_mask uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.gray_pixel (gray_pixel),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.mask_bit   (mask_bit),
		.pixel_row  (pixel_row),
		.pixel_col  (pixel_col),
		.frame_done (frame_done),
		.run_last   (run_last)
	);

	mask_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.gray_pixel (gray_pixel),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.mask_bit   (mask_bit),
		.pixel_row  (pixel_row),
		.pixel_col  (pixel_col),
		.frame_done (frame_done),
		.run_last   (run_last),
		.masks_owed (masks_owed),
		.mismatches (mismatches)
	);

	// register write: one cycle of cfg_we, driven on the falling edge
	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
		if (idx == REG_LOW_THR) low_now = val[PIX_W-1:0];
		if (idx == REG_HIGH_THR) high_now = val[PIX_W-1:0];
	endtask

	task automatic set_size(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
		write_reg(REG_FRAME_W, w);
		write_reg(REG_FRAME_H, h);
	endtask

	// stop offering, wait for every owed result, then let a row-0 item in
	// flight (no result of its own) clear the pipe
	task automatic wait_quiet();
		@(negedge clk);
		in_valid <= 1'b0;
		while (masks_owed != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// one pixel item; bursts of random length with random gaps between them
	task automatic send_pixel(input logic [PIX_W-1:0] pix);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(40, 1);
			gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
			if (gap != 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid   <= 1'b1;
		gray_pixel <= pix;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// levels aimed at each class under the current thresholds, plus uniform
	function automatic logic [PIX_W-1:0] pick_level();
		case ($urandom_range(3, 0))
			0: return PIX_W'($urandom_range(255, 0));
			1: return (low_now > 0) ? PIX_W'($urandom_range(low_now - 1, 0))
			                        : PIX_W'($urandom_range(255, 0));
			2: return (high_now > low_now) ? PIX_W'($urandom_range(high_now - 1, low_now))
			                               : PIX_W'($urandom_range(255, 0));
			default: return PIX_W'($urandom_range(255, high_now));
		endcase
	endfunction

	function automatic logic [PIX_W-1:0] pick_threshold();
		case ($urandom_range(5, 0))
			0: return '0;
			1: return '1;
			default: return PIX_W'($urandom_range(255, 0));
		endcase
	endfunction

	task automatic send_levels(input int unsigned n);
		for (int unsigned k = 0; k < n; k++) send_pixel(pick_level());
	endtask

	// receiver: segments of random length, each with its own ready pattern,
	// plus one long hold-off as soon as it is requested, while the sender
	// keeps going
	initial begin
		int unsigned seg, mode;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			seg  = $urandom_range(60, 10);
			mode = $urandom_range(3, 0);
			for (int unsigned k = 0; k < seg; k++) begin
				@(negedge clk);
				if (hold_request && !hold_done) begin
					out_ready <= 1'b0;
					repeat (80) @(negedge clk);
					hold_done = 1'b1;
				end
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= $urandom_range(1, 0);
					2: out_ready <= (k % 3 == 0);
					default: out_ready <= ($urandom_range(3, 0) != 0);
				endcase
			end
		end
	end

	initial begin
		int unsigned fr, wv, hv, guard;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = REG_LOW_THR;
		cfg_data     = '0;
		in_valid     = 1'b0;
		gray_pixel   = '0;
		small_items  = 0;
		burst_left   = 0;
		low_now      = LOW_THR_RST;
		high_now     = HIGH_THR_RST;
		hold_request = 1'b0;
		hold_done    = 1'b0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// low above high (200 / 100), with junk in the upper data bits;
		// sizes written as 0 clamp to a 1x1 frame, one result per pixel
		write_reg(REG_LOW_THR, 11'h7C8);
		write_reg(REG_HIGH_THR, 11'h364);
		set_size(11'd0, 11'd0);
		send_pixel(8'd150);
		send_pixel(8'd255);
		send_pixel(8'd199);
		send_pixel(8'd0);
		wait_quiet();

		// each of the four neighbors alone makes a middle pixel foreground
		write_reg(REG_LOW_THR, 11'd100);
		write_reg(REG_HIGH_THR, 11'd200);
		set_size(11'd4, 11'd4);
		for (int i = 0; i < 16; i++) send_pixel(NEIGHBOR_GRID[(15 - i) * PIX_W +: PIX_W]);

		// random frames, config changed between frames with the block idle
		fr = 0;
		while (small_items < 500) begin
			wait_quiet();
			if (fr == 3) begin
				// out-of-range sizes: a wide row and a tall column, each cut
				// short by a later size write; the long receiver hold-off
				// lands inside the wide row so the input stalls
				write_reg(REG_LOW_THR, 11'd80);
				write_reg(REG_HIGH_THR, 11'd170);
				set_size(11'd2047, 11'd1);
				hold_request = 1'b1;
				send_levels(40);
				wait_quiet();
				write_reg(REG_FRAME_W, 11'd41);
				send_levels(1);
				wait_quiet();
				set_size(11'd1, 11'd1500);
				send_levels(30);
				wait_quiet();
				write_reg(REG_FRAME_H, 11'd31);
				send_levels(1);
				small_items += 72;
			end else if (fr == 6) begin
				// height cut mid-frame: row 2 turns into the last row
				set_size(11'd5, 11'd6);
				send_levels(10);
				wait_quiet();
				write_reg(REG_FRAME_H, 11'd3);
				send_levels(5);
				small_items += 15;
			end else if (fr == 12) begin
				// width cut at a row boundary: later rows only read written columns
				set_size(11'd6, 11'd5);
				send_levels(12);
				wait_quiet();
				write_reg(REG_FRAME_W, 11'd3);
				send_levels(9);
				small_items += 21;
			end else begin
				if ($urandom_range(1, 0) == 1) begin
					write_reg(REG_LOW_THR, {3'($urandom_range(7, 0)), pick_threshold()});
					write_reg(REG_HIGH_THR, {3'($urandom_range(7, 0)), pick_threshold()});
				end
				wv = ($urandom_range(9, 0) == 0) ? 0 : $urandom_range(12, 1);
				hv = ($urandom_range(9, 0) == 0) ? 0 : $urandom_range(8, 1);
				set_size(CFG_DATA_W'(wv), CFG_DATA_W'(hv));
				if (wv == 0) wv = 1;
				if (hv == 0) hv = 1;
				send_levels(wv * hv);
				small_items += wv * hv;
			end
			fr++;
		end

		// drain, then keep waiting to catch any stray result
		@(negedge clk);
		in_valid <= 1'b0;
		for (guard = 0; masks_owed != 0 && guard < 20000; guard++) @(negedge clk);
		repeat (20) @(negedge clk);
		if (mismatches == 0 && masks_owed == 0) begin
			$display("tb_top: PASS");
		end else begin
			if (masks_owed != 0) $display("%0t ns: %0d results never arrived", $time, masks_owed);
			$display("tb_top: FAIL");
		end
		$finish;
	end

	// hard stop, far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("%0t ns: run timed out", $time);
		$display("tb_top: FAIL");
		$finish;
	end

endmodule
